@@ sv/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the triangle circumcircle pipeline
// Widths of the intermediate values, the status codes and the stage payloads.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int CRD_W = 16;   // input coordinate width
	localparam int DIF_W = 17;   // coordinate difference
	localparam int PRD_W = 34;   // product of two differences
	localparam int DET_W = 35;   // signed determinant
	localparam int DAB_W = 34;   // absolute determinant
	localparam int LEN_W = 34;   // squared side length
	localparam int DV_W  = 35;   // center divisor, twice the absolute determinant
	localparam int NUM_W = 52;   // center numerator
	localparam int D2_W  = 67;   // squared determinant
	localparam int P_W   = 100;  // product of the three squared lengths
	localparam int QC_W  = 25;   // center quotient bits kept
	localparam int QR_W  = 51;   // radius quotient bits kept
	localparam int RAD_W = 24;   // radius result width
	localparam int OUT_W = 24;   // center result width
	localparam int CMP_C_W = DV_W + QC_W;  // center divide compare width
	localparam int CMP_R_W = D2_W + QR_W;  // radius divide compare width

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_COLL = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	localparam logic [RAD_W-1:0] RAD_MAX = 24'hFFFFFF;
	// (2*RAD_MAX - 1)^2: at or above this squared quotient the radius saturates.
	localparam logic [QR_W-1:0] RAD_SAT_SQ = 51'd1125899705516041;
	localparam logic signed [26:0] CEN_MAX = 27'sd8388607;
	localparam logic signed [26:0] CEN_MIN = -27'sd8388608;

	// Payload through the long division stages.
	typedef struct packed {
		logic                    col;
		logic signed [CRD_W-1:0] base_x;
		logic signed [CRD_W-1:0] base_y;
		logic                    neg_x;
		logic                    neg_y;
		logic                    ov_x;
		logic                    ov_y;
		logic                    ov_r;
		logic [NUM_W-1:0]        rem_x;
		logic [NUM_W-1:0]        rem_y;
		logic [DV_W-1:0]         dv;
		logic [QC_W-1:0]         q_x;
		logic [QC_W-1:0]         q_y;
		logic [P_W-1:0]          rem_r;
		logic [D2_W-1:0]         d2;
		logic [QR_W-1:0]         q_r;
	} div_t;

	// Payload through the square root stages.
	typedef struct packed {
		logic                    col;
		logic signed [CRD_W-1:0] base_x;
		logic signed [CRD_W-1:0] base_y;
		logic                    neg_x;
		logic                    neg_y;
		logic                    ov_x;
		logic                    ov_y;
		logic                    ov_r;
		logic [QC_W-1:0]         q_x;
		logic [QC_W-1:0]         q_y;
		logic [QR_W-1:0]         q_r;
		logic [RAD_W-1:0]        rad;
		logic [2*RAD_W-1:0]      rad_sq;
	} sq_t;

endpackage

@@ sv/tcc_front.sv @@
// ----------------------------------------------------------------------------
// tcc_front: determinant, side lengths, numerators and dividends
// Seven register stages from the three points to the division operands.
// ----------------------------------------------------------------------------
module tcc_front #(
	parameter int CWU = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [31:0]                limit,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [6*tcc_pkg::CRD_W-1:0] in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tcc_pkg::div_t              out_data
);

	localparam int NST = 7;
	localparam int SH = tcc_pkg::CRD_W - CWU;

	logic [NST-1:0] vld_s;
	logic [NST:0]   go;
	logic [NST:0]   src_v;

	assign go[NST] = out_ready;
	assign src_v[0] = in_valid;
	genvar i;
	for (i = 0; i < NST; i++) begin : g_ctl
		assign go[i] = !vld_s[i] || go[i+1];
		assign src_v[i+1] = vld_s[i];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (go[i]) begin
				vld_s[i] <= src_v[i];
			end
		end
	end
	assign in_ready = go[0];
	assign out_valid = vld_s[NST-1];

	// Sign extension from the configured coordinate width.
	logic signed [15:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
	assign ax_e = $signed(in_data[15:0] << SH) >>> SH;
	assign ay_e = $signed(in_data[31:16] << SH) >>> SH;
	assign bx_e = $signed(in_data[47:32] << SH) >>> SH;
	assign by_e = $signed(in_data[63:48] << SH) >>> SH;
	assign cx_e = $signed(in_data[79:64] << SH) >>> SH;
	assign cy_e = $signed(in_data[95:80] << SH) >>> SH;

	// Stage 1: edge vectors.
	logic signed [tcc_pkg::DIF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [15:0] ax_s1, ay_s1;
	always_ff @(posedge clk) begin
		if (go[0]) begin
			ux_s1 <= bx_e - ax_e;
			uy_s1 <= by_e - ay_e;
			vx_s1 <= cx_e - ax_e;
			vy_s1 <= cy_e - ay_e;
			wx_s1 <= cx_e - bx_e;
			wy_s1 <= cy_e - by_e;
			ax_s1 <= ax_e;
			ay_s1 <= ay_e;
		end
	end

	// Stage 2: cross products and squares.
	logic signed [tcc_pkg::PRD_W-1:0] pa_s2, pb_s2, sux_s2, suy_s2, svx_s2, svy_s2,
		swx_s2, swy_s2;
	logic signed [tcc_pkg::DIF_W-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [15:0] ax_s2, ay_s2;
	always_ff @(posedge clk) begin
		if (go[1]) begin
			pa_s2  <= ux_s1 * vy_s1;
			pb_s2  <= uy_s1 * vx_s1;
			sux_s2 <= ux_s1 * ux_s1;
			suy_s2 <= uy_s1 * uy_s1;
			svx_s2 <= vx_s1 * vx_s1;
			svy_s2 <= vy_s1 * vy_s1;
			swx_s2 <= wx_s1 * wx_s1;
			swy_s2 <= wy_s1 * wy_s1;
			ux_s2  <= ux_s1;
			uy_s2  <= uy_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
		end
	end

	// Stage 3: determinant and squared lengths.
	logic signed [tcc_pkg::DET_W-1:0] det_s3;
	logic [tcc_pkg::LEN_W-1:0] lu_s3, lv_s3, lw_s3;
	logic signed [tcc_pkg::DIF_W-1:0] ux_s3, uy_s3, vx_s3, vy_s3;
	logic signed [15:0] ax_s3, ay_s3;
	always_ff @(posedge clk) begin
		if (go[2]) begin
			det_s3 <= pa_s2 - pb_s2;
			lu_s3  <= tcc_pkg::LEN_W'(sux_s2 + suy_s2);
			lv_s3  <= tcc_pkg::LEN_W'(svx_s2 + svy_s2);
			lw_s3  <= tcc_pkg::LEN_W'(swx_s2 + swy_s2);
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
		end
	end

	// Stage 4: absolute determinant, collinear test, numerator terms, squared determinant and length product.
	logic [tcc_pkg::DET_W-1:0] det_neg;
	logic [tcc_pkg::DAB_W-1:0] dabs_c;
	assign det_neg = tcc_pkg::DET_W'(-det_s3);
	assign dabs_c = det_s3[tcc_pkg::DET_W-1] ? det_neg[tcc_pkg::DAB_W-1:0]
		: det_s3[tcc_pkg::DAB_W-1:0];

	logic signed [tcc_pkg::NUM_W-1:0] t1_s4, t2_s4, t3_s4, t4_s4;
	logic [tcc_pkg::D2_W-1:0] d2_s4;
	logic [2*tcc_pkg::LEN_W-2:0] luv_s4;
	logic [tcc_pkg::LEN_W-1:0] lw_s4;
	logic [tcc_pkg::DAB_W-1:0] dabs_s4;
	logic dneg_s4, col_s4;
	logic signed [15:0] ax_s4, ay_s4;
	always_ff @(posedge clk) begin
		if (go[3]) begin
			t1_s4   <= $signed({1'b0, lu_s3}) * vy_s3;
			t2_s4   <= $signed({1'b0, lv_s3}) * uy_s3;
			t3_s4   <= $signed({1'b0, lv_s3}) * ux_s3;
			t4_s4   <= $signed({1'b0, lu_s3}) * vx_s3;
			d2_s4   <= det_s3 * det_s3;
			luv_s4  <= lu_s3 * lv_s3;
			lw_s4   <= lw_s3;
			dabs_s4 <= dabs_c;
			dneg_s4 <= det_s3[tcc_pkg::DET_W-1];
			col_s4  <= dabs_c <= {2'b0, limit};
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
		end
	end

	// Stage 5: numerators and partial products of the length product.
	logic signed [tcc_pkg::NUM_W-1:0] numx_s5, numy_s5;
	logic [2*tcc_pkg::LEN_W-1:0] plo_s5;
	logic [2*tcc_pkg::LEN_W-2:0] phi_s5;
	logic [tcc_pkg::D2_W-1:0] d2_s5;
	logic [tcc_pkg::DAB_W-1:0] dabs_s5;
	logic dneg_s5, col_s5;
	logic signed [15:0] ax_s5, ay_s5;
	always_ff @(posedge clk) begin
		if (go[4]) begin
			numx_s5 <= t1_s4 - t2_s4;
			numy_s5 <= t3_s4 - t4_s4;
			plo_s5  <= luv_s4[tcc_pkg::LEN_W-1:0] * lw_s4;
			phi_s5  <= luv_s4[2*tcc_pkg::LEN_W-2:tcc_pkg::LEN_W] * lw_s4;
			d2_s5   <= d2_s4;
			dabs_s5 <= dabs_s4;
			dneg_s5 <= dneg_s4;
			col_s5  <= col_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
		end
	end

	// Stage 6: dividends, rounding offset folded into the center dividend.
	logic [tcc_pkg::NUM_W-1:0] nxm, nym;
	assign nxm = numx_s5[tcc_pkg::NUM_W-1] ? tcc_pkg::NUM_W'(-numx_s5)
		: tcc_pkg::NUM_W'(numx_s5);
	assign nym = numy_s5[tcc_pkg::NUM_W-1] ? tcc_pkg::NUM_W'(-numy_s5)
		: tcc_pkg::NUM_W'(numy_s5);

	logic [tcc_pkg::P_W-1:0] p_s6;
	logic [tcc_pkg::NUM_W-1:0] nx_s6, ny_s6;
	logic [tcc_pkg::DV_W-1:0] dv_s6;
	logic [tcc_pkg::D2_W-1:0] d2_s6;
	logic negx_s6, negy_s6, col_s6;
	logic signed [15:0] ax_s6, ay_s6;
	always_ff @(posedge clk) begin
		if (go[5]) begin
			p_s6    <= tcc_pkg::P_W'(plo_s5) + (tcc_pkg::P_W'(phi_s5) << tcc_pkg::LEN_W);
			nx_s6   <= nxm + tcc_pkg::NUM_W'(dabs_s5);
			ny_s6   <= nym + tcc_pkg::NUM_W'(dabs_s5);
			negx_s6 <= numx_s5[tcc_pkg::NUM_W-1] ^ dneg_s5;
			negy_s6 <= numy_s5[tcc_pkg::NUM_W-1] ^ dneg_s5;
			dv_s6   <= {dabs_s5, 1'b0};
			d2_s6   <= d2_s5;
			col_s6  <= col_s5;
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
		end
	end

	// Stage 7: quotient range checks ahead of the long division.
	logic [tcc_pkg::CMP_C_W-1:0] dv_top;
	logic [tcc_pkg::CMP_R_W-1:0] d2_top;
	tcc_pkg::div_t nxt7;
	assign dv_top = tcc_pkg::CMP_C_W'(dv_s6) << tcc_pkg::QC_W;
	assign d2_top = tcc_pkg::CMP_R_W'(d2_s6) << tcc_pkg::QR_W;
	always_comb begin
		nxt7.col    = col_s6;
		nxt7.base_x = ax_s6;
		nxt7.base_y = ay_s6;
		nxt7.neg_x  = negx_s6;
		nxt7.neg_y  = negy_s6;
		nxt7.ov_x   = tcc_pkg::CMP_C_W'(nx_s6) >= dv_top;
		nxt7.ov_y   = tcc_pkg::CMP_C_W'(ny_s6) >= dv_top;
		nxt7.ov_r   = tcc_pkg::CMP_R_W'(p_s6) >= d2_top;
		nxt7.rem_x  = nx_s6;
		nxt7.rem_y  = ny_s6;
		nxt7.dv     = dv_s6;
		nxt7.q_x    = '0;
		nxt7.q_y    = '0;
		nxt7.rem_r  = p_s6;
		nxt7.d2     = d2_s6;
		nxt7.q_r    = '0;
	end

	tcc_pkg::div_t item_s7;
	always_ff @(posedge clk) begin
		if (go[6]) begin
			item_s7 <= nxt7;
		end
	end
	assign out_data = item_s7;

endmodule

@@ sv/tcc_div.sv @@
// ----------------------------------------------------------------------------
// tcc_div: restoring long division, one quotient bit per stage
// The radius quotient takes every stage; the two center quotients run in the
// first stages beside it.
// ----------------------------------------------------------------------------
module tcc_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tcc_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tcc_pkg::div_t out_data
);

	localparam int NST = tcc_pkg::QR_W;
	localparam int CW = tcc_pkg::CMP_C_W;
	localparam int RW = tcc_pkg::CMP_R_W;

	logic [NST-1:0] vld_s;
	logic [NST:0]   go;
	logic [NST:0]   src_v;
	tcc_pkg::div_t  src [0:NST];
	tcc_pkg::div_t  nxt [0:NST-1];
	tcc_pkg::div_t  item_s [0:NST-1];

	assign go[NST] = out_ready;
	assign src_v[0] = in_valid;
	assign src[0] = in_data;

	genvar j;
	for (j = 0; j < NST; j++) begin : g_st
		localparam int KR = NST - 1 - j;
		logic [tcc_pkg::NUM_W-1:0] rx_n, ry_n;
		logic [tcc_pkg::QC_W-1:0]  qx_n, qy_n;

		if (j < tcc_pkg::QC_W) begin : g_c
			localparam int KC = tcc_pkg::QC_W - 1 - j;
			logic [CW-1:0] dsh;
			assign dsh = CW'(src[j].dv) << KC;
			always_comb begin
				rx_n = src[j].rem_x;
				ry_n = src[j].rem_y;
				qx_n = src[j].q_x;
				qy_n = src[j].q_y;
				if (CW'(src[j].rem_x) >= dsh) begin
					rx_n = src[j].rem_x - dsh[tcc_pkg::NUM_W-1:0];
					qx_n[KC] = 1'b1;
				end
				if (CW'(src[j].rem_y) >= dsh) begin
					ry_n = src[j].rem_y - dsh[tcc_pkg::NUM_W-1:0];
					qy_n[KC] = 1'b1;
				end
			end
		end else begin : g_nc
			assign rx_n = src[j].rem_x;
			assign ry_n = src[j].rem_y;
			assign qx_n = src[j].q_x;
			assign qy_n = src[j].q_y;
		end

		logic [RW-1:0] rsh;
		assign rsh = RW'(src[j].d2) << KR;
		always_comb begin
			nxt[j] = src[j];
			nxt[j].rem_x = rx_n;
			nxt[j].rem_y = ry_n;
			nxt[j].q_x = qx_n;
			nxt[j].q_y = qy_n;
			if (RW'(src[j].rem_r) >= rsh) begin
				nxt[j].rem_r = src[j].rem_r - rsh[tcc_pkg::P_W-1:0];
				nxt[j].q_r[KR] = 1'b1;
			end
		end

		assign go[j] = !vld_s[j] || go[j+1];
		assign src_v[j+1] = vld_s[j];
		assign src[j+1] = item_s[j];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (go[j]) begin
				vld_s[j] <= src_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (go[j]) begin
				item_s[j] <= nxt[j];
			end
		end
	end

	assign in_ready = go[0];
	assign out_valid = vld_s[NST-1];
	assign out_data = src[NST];

endmodule

@@ sv/tcc_sqrt.sv @@
// ----------------------------------------------------------------------------
// tcc_sqrt: bit-by-bit radius search over the squared-radius quotient
// Each stage tries one radius bit, keeping the square up to date by adds.
// ----------------------------------------------------------------------------
module tcc_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tcc_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tcc_pkg::sq_t  out_data
);

	localparam int NST = tcc_pkg::RAD_W;
	localparam int SW = 2 * tcc_pkg::RAD_W;

	logic [NST-1:0] vld_s;
	logic [NST:0]   go;
	logic [NST:0]   src_v;
	tcc_pkg::sq_t   src [0:NST];
	tcc_pkg::sq_t   nxt [0:NST-1];
	tcc_pkg::sq_t   item_s [0:NST-1];

	always_comb begin
		src[0].col    = in_data.col;
		src[0].base_x = in_data.base_x;
		src[0].base_y = in_data.base_y;
		src[0].neg_x  = in_data.neg_x;
		src[0].neg_y  = in_data.neg_y;
		src[0].ov_x   = in_data.ov_x;
		src[0].ov_y   = in_data.ov_y;
		src[0].ov_r   = in_data.ov_r;
		src[0].q_x    = in_data.q_x;
		src[0].q_y    = in_data.q_y;
		src[0].q_r    = in_data.q_r;
		src[0].rad    = '0;
		src[0].rad_sq = '0;
	end

	assign go[NST] = out_ready;
	assign src_v[0] = in_valid;

	genvar j;
	for (j = 0; j < NST; j++) begin : g_st
		localparam int B = NST - 1 - j;
		logic [tcc_pkg::RAD_W-1:0] cand;
		logic [SW-1:0] csq;
		logic [SW+1:0] t2;

		// Candidate radius r tests (2r - 1)^2 against the quotient.
		assign cand = src[j].rad | (tcc_pkg::RAD_W'(1) << B);
		assign csq = src[j].rad_sq + (SW'(src[j].rad) << (B + 1)) + (SW'(1) << (2 * B));
		assign t2 = {csq, 2'b00} - {{tcc_pkg::RAD_W{1'b0}}, cand, 2'b00} + (SW+2)'(1);

		always_comb begin
			nxt[j] = src[j];
			if ({1'b0, t2} <= src[j].q_r) begin
				nxt[j].rad = cand;
				nxt[j].rad_sq = csq;
			end
		end

		assign go[j] = !vld_s[j] || go[j+1];
		assign src_v[j+1] = vld_s[j];
		assign src[j+1] = item_s[j];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (go[j]) begin
				vld_s[j] <= src_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (go[j]) begin
				item_s[j] <= nxt[j];
			end
		end
	end

	assign in_ready = go[0];
	assign out_valid = vld_s[NST-1];
	assign out_data = src[NST];

endmodule

@@ sv/triangle_circumcircle.sv @@
// ----------------------------------------------------------------------------
// triangle_circumcircle: circumcenter and circumradius of a point triple
// Fixed-point pipeline from three Q12.4 points to a Q20.4 center and radius.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Word                                   Handshake
// s_*      in         ax, ay, bx, by_coord, cx, cy (96 bits)  tvalid/tready
// m_*      out        center_x, center_y, circle_radius;      tvalid/tready
//                     tuser carries status
// cfg_*    in         collinear_limit (32 bits)               write enable only
//
// One word enters per cycle while s_tready is high; a word passes through seven
// setup stages, 51 long-division stages (one radius-quotient bit each, the
// center quotients riding in the first 25), 24 square-root stages, and the
// output register. Reset clears the valid bits and the limit register only.
// A stalled output stalls just the stages behind it that hold words; empty
// stages keep filling, so bubbles close up while the result waits.
//
module triangle_circumcircle #(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// ax [15:0], ay [31:16], bx [47:32], by_coord [63:48], cx [79:64], cy [95:80]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// center_x [23:0], center_y [47:24], circle_radius [71:48]
	output logic [71:0] m_tdata,
	// status [1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// Coordinates wider than 16 bits are treated as 16.
	localparam int CWU = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;

	logic [31:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	logic          fr_valid, fr_ready;
	tcc_pkg::div_t fr_data;
	logic          dv_valid, dv_ready;
	tcc_pkg::div_t dv_data;
	logic          sq_valid, sq_ready;
	tcc_pkg::sq_t  sq_data;

	tcc_front #(
		.CWU(CWU)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.limit(limit_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_data(s_tdata),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_data(fr_data)
	);

	tcc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.in_ready(fr_ready),
		.in_data(fr_data),
		.out_valid(dv_valid),
		.out_ready(dv_ready),
		.out_data(dv_data)
	);

	tcc_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(dv_valid),
		.in_ready(dv_ready),
		.in_data(dv_data),
		.out_valid(sq_valid),
		.out_ready(sq_ready),
		.out_data(sq_data)
	);

	// Final stage: apply the rounded offsets to the first point, clamp the
	// center, saturate the radius, zero a collinear word and form the status.
	logic signed [26:0] offx, offy, sumx, sumy;
	logic [23:0] cenx, ceny, rad;
	logic satx, saty, satr;
	tcc_pkg::status_t st;

	assign offx = sq_data.neg_x ? -$signed({2'b00, sq_data.q_x}) : $signed({2'b00, sq_data.q_x});
	assign offy = sq_data.neg_y ? -$signed({2'b00, sq_data.q_y}) : $signed({2'b00, sq_data.q_y});
	assign sumx = sq_data.base_x + offx;
	assign sumy = sq_data.base_y + offy;

	always_comb begin
		satx = 1'b1;
		if (sq_data.ov_x) begin
			cenx = sq_data.neg_x ? tcc_pkg::CEN_MIN[23:0] : tcc_pkg::CEN_MAX[23:0];
		end else if (sumx > tcc_pkg::CEN_MAX) begin
			cenx = tcc_pkg::CEN_MAX[23:0];
		end else if (sumx < tcc_pkg::CEN_MIN) begin
			cenx = tcc_pkg::CEN_MIN[23:0];
		end else begin
			cenx = sumx[23:0];
			satx = 1'b0;
		end

		saty = 1'b1;
		if (sq_data.ov_y) begin
			ceny = sq_data.neg_y ? tcc_pkg::CEN_MIN[23:0] : tcc_pkg::CEN_MAX[23:0];
		end else if (sumy > tcc_pkg::CEN_MAX) begin
			ceny = tcc_pkg::CEN_MAX[23:0];
		end else if (sumy < tcc_pkg::CEN_MIN) begin
			ceny = tcc_pkg::CEN_MIN[23:0];
		end else begin
			ceny = sumy[23:0];
			saty = 1'b0;
		end

		// A quotient at or above the top test value means the radius rounds to the limit.
		satr = sq_data.ov_r || (sq_data.q_r >= tcc_pkg::RAD_SAT_SQ);
		rad = satr ? tcc_pkg::RAD_MAX : sq_data.rad;

		if (sq_data.col) begin
			cenx = '0;
			ceny = '0;
			rad = '0;
			st = tcc_pkg::ST_COLL;
		end else if (satx || saty || satr) begin
			st = tcc_pkg::ST_SAT;
		end else begin
			st = tcc_pkg::ST_OK;
		end
	end

	// Output register; it reloads whenever it is empty or being drained.
	logic        out_vld_q;
	logic [71:0] out_data_q;
	logic [1:0]  out_user_q;

	assign sq_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (sq_ready) begin
			out_vld_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_ready) begin
			out_data_q <= {rad, ceny, cenx};
			out_user_q <= st;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

`ifndef SYNTHESIS
	a_coll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tcc_pkg::ST_COLL) |-> (m_tdata == '0))
		else $error("collinear word carries nonzero fields");

	a_rad_max_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[71:48] == tcc_pkg::RAD_MAX) |-> (m_tuser == tcc_pkg::ST_SAT))
		else $error("full-scale radius without saturated status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == tcc_pkg::ST_OK) || (m_tuser == tcc_pkg::ST_COLL)
			|| (m_tuser == tcc_pkg::ST_SAT))
		else $error("undefined status code");

	a_drain_reload: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && sq_valid |=> m_tvalid)
		else $error("empty output register did not take a finished word");
`endif

endmodule
